### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------

// same-cycle implication
`define SKOF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKOF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/skof_pkg.sv
// ----------------------------------------------------------------------------
// skof_pkg
// Types and constants for the scalar Kalman filter with outlier restart.
// ----------------------------------------------------------------------------
package skof_pkg;

    localparam int SAMPLE_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS   = 30;

    localparam int DIV_STEPS = GAIN_FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] ONE_Q30  = 32'(64'd1 << GAIN_FRAC_BITS);
    localparam logic [62:0] HALF_Q30 = 63'(64'd1 << (GAIN_FRAC_BITS - 1));

    localparam logic [30:0] LIMIT_RESET       = 31'(64'd1 << SAMPLE_FRAC_BITS);
    localparam logic [7:0]  COUNT_LIMIT_RESET = 8'd10;
    localparam logic [31:0] PROC_NOISE_RESET  = 32'd0;
    localparam logic [31:0] MEAS_NOISE_RESET  = 32'd53687091;

    typedef enum logic [1:0] {
        REG_OUTLIER_LIMIT = 2'd0,
        REG_COUNT_LIMIT   = 2'd1,
        REG_PROCESS_NOISE = 2'd2,
        REG_MEASURE_NOISE = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PREDICT,
        S_DEN,
        S_DIV,
        S_MUL_EST,
        S_RND_EST,
        S_UPDATE,
        S_DONE
    } state_t;

endpackage

### rtl/core/scalar_kalman_outlier_filter_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_outlier_filter_top
// Scalar Kalman filter on Q16.16 samples with outlier counting and restart.
// ----------------------------------------------------------------------------
// One sample word is taken at a time and one result word comes back for it.
// A sample goes through check, predict, denominator, divide, multiply, round,
// update and done, then back to idle; s_ready is low while a sample is in
// flight. The gain divide is a restoring divider that produces one quotient
// bit per cycle, 31 bits in all; the two multiplies share one 31x32
// multiplier. A finished result waits in the output register while the next
// sample is accepted; the sequencer holds in its last step only if that
// register is still full when the next result is ready. Registers sit on an
// APB-style port at byte offsets 0x0 (outlier limit, Q16.16, zero means 1.0),
// 0x4 (outlier count limit), 0x8 (process noise Q, Q2.30) and 0xC
// (measurement noise R, Q2.30); write them only while the block is idle.
`include "assert_macros.svh"

module scalar_kalman_outlier_filter_top (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_estimate,
    output logic               m_restarted,
    output logic               m_outlier,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import skof_pkg::*;

    // configuration
    logic [30:0] outlier_limit_reg;
    logic [7:0]  count_limit_reg;
    logic [31:0] process_noise_reg;
    logic [31:0] measure_noise_reg;

    // filter state
    state_t      state_reg, state_next;
    logic [31:0] est_reg, est_next;
    logic [31:0] cov_reg, cov_next;
    logic [7:0]  ocnt_reg, ocnt_next;

    // working registers
    logic [31:0]          sample_reg, sample_next;
    logic                 outl_reg, outl_next;
    logic                 rst_flag_reg, rst_flag_next;
    logic [31:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          pp_reg, pp_next;
    logic [32:0]          den_reg, den_next;
    logic [32:0]          rem_reg, rem_next;
    logic [30:0]          gain_reg, gain_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [62:0]          prod_reg, prod_next;
    logic [32:0]          delta_reg, delta_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_est_reg, m_est_next;
    logic        m_rst_reg, m_rst_next;
    logic        m_outl_reg, m_outl_next;

    logic        cfg_wr;
    logic [30:0] limit_eff;
    logic [32:0] diff;
    logic [32:0] diff_abs;
    logic        dev_over;
    logic [32:0] pq_sum;
    logic [33:0] trial;
    logic        trial_ge;
    logic [30:0] mul_a;
    logic [31:0] mul_b;
    logic [62:0] mul_p;
    logic [62:0] prod_rnd;
    logic [34:0] est_sum;
    logic [32:0] np;
    logic        out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outlier_limit_reg <= LIMIT_RESET;
            count_limit_reg   <= COUNT_LIMIT_RESET;
            process_noise_reg <= PROC_NOISE_RESET;
            measure_noise_reg <= MEAS_NOISE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_OUTLIER_LIMIT: outlier_limit_reg <= pwdata[30:0];
                REG_COUNT_LIMIT:   count_limit_reg   <= pwdata[7:0];
                REG_PROCESS_NOISE: process_noise_reg <= pwdata;
                REG_MEASURE_NOISE: measure_noise_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_OUTLIER_LIMIT: prdata = {1'b0, outlier_limit_reg};
            REG_COUNT_LIMIT:   prdata = {24'd0, count_limit_reg};
            REG_PROCESS_NOISE: prdata = process_noise_reg;
            REG_MEASURE_NOISE: prdata = measure_noise_reg;
            default:           prdata = '0;
        endcase
    end

    // ---------------- shared datapath pieces ----------------
    assign limit_eff = (outlier_limit_reg == '0) ? LIMIT_RESET : outlier_limit_reg;

    // sample - estimate, exact in 33 bits
    assign diff     = {sample_reg[31], sample_reg} - {est_reg[31], est_reg};
    assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
    assign dev_over = diff_abs > {2'b00, limit_eff};

    assign pq_sum = {1'b0, cov_reg} + {1'b0, process_noise_reg};

    // restoring divide step; first step compares pp itself
    assign trial    = (div_cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign trial_ge = trial >= {1'b0, den_reg};

    // one multiplier for both blends
    assign mul_a = (state_reg == S_MUL_EST) ? gain_reg : (ONE_Q30[30:0] - gain_reg);
    assign mul_b = (state_reg == S_MUL_EST) ? mag_reg  : pp_reg;
    assign mul_p = 63'(mul_a) * 63'(mul_b);

    assign prod_rnd = prod_reg + HALF_Q30;
    assign est_sum  = neg_reg ? ({{3{est_reg[31]}}, est_reg} - {2'b00, delta_reg})
                              : ({{3{est_reg[31]}}, est_reg} + {2'b00, delta_reg});
    assign np       = prod_rnd[62:30];

    assign out_free = !m_valid_reg || m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        est_next      = est_reg;
        cov_next      = cov_reg;
        ocnt_next     = ocnt_reg;
        sample_next   = sample_reg;
        outl_next     = outl_reg;
        rst_flag_next = rst_flag_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        pp_next       = pp_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        gain_next     = gain_reg;
        div_cnt_next  = div_cnt_reg;
        prod_next     = prod_reg;
        delta_next    = delta_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_est_next    = m_est_reg;
        m_rst_next    = m_rst_reg;
        m_outl_next   = m_outl_reg;
        s_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sample_next = s_sample;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                outl_next     = dev_over;
                rst_flag_next = 1'b0;
                if (dev_over) begin
                    if (ocnt_reg < count_limit_reg) begin
                        ocnt_next = ocnt_reg + 8'd1;
                    end else begin
                        est_next      = '0;
                        cov_next      = ONE_Q30;
                        ocnt_next     = '0;
                        rst_flag_next = 1'b1;
                    end
                end else begin
                    ocnt_next = '0;
                end
                state_next = S_PREDICT;
            end
            S_PREDICT: begin
                // estimate may have been cleared by a restart
                pp_next    = pq_sum[32] ? '1 : pq_sum[31:0];
                mag_next   = diff_abs[31:0];
                neg_next   = diff[32];
                state_next = S_DEN;
            end
            S_DEN: begin
                den_next     = {1'b0, pp_reg} + {1'b0, measure_noise_reg};
                rem_next     = {1'b0, pp_reg};
                gain_next    = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                rem_next = trial_ge ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    gain_next  = (den_reg == '0) ? '0 : {gain_reg[29:0], trial_ge};
                    state_next = S_MUL_EST;
                end else begin
                    gain_next    = {gain_reg[29:0], trial_ge};
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                end
            end
            S_MUL_EST: begin
                prod_next  = mul_p;
                state_next = S_RND_EST;
            end
            S_RND_EST: begin
                delta_next = prod_rnd[62:30];
                prod_next  = mul_p;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if ($signed(est_sum) > 35'sd2147483647) begin
                    est_next = 32'h7FFF_FFFF;
                end else if ($signed(est_sum) < -35'sd2147483648) begin
                    est_next = 32'h8000_0000;
                end else begin
                    est_next = est_sum[31:0];
                end
                cov_next   = np[32] ? '1 : np[31:0];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_est_next   = est_reg;
                    m_rst_next   = rst_flag_reg;
                    m_outl_next  = outl_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            est_reg     <= '0;
            cov_reg     <= ONE_Q30;
            ocnt_reg    <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            est_reg     <= est_next;
            cov_reg     <= cov_next;
            ocnt_reg    <= ocnt_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        outl_reg     <= outl_next;
        rst_flag_reg <= rst_flag_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        pp_reg       <= pp_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        gain_reg     <= gain_next;
        prod_reg     <= prod_next;
        delta_reg    <= delta_next;
        m_est_reg    <= m_est_next;
        m_rst_reg    <= m_rst_next;
        m_outl_reg   <= m_outl_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_estimate  = m_est_reg;
    assign m_restarted = m_rst_reg;
    assign m_outlier   = m_outl_reg;

    // ---------------- assertions ----------------
    `SKOF_ASSERT_IMP(a_gain_le_one, state_reg == S_MUL_EST, gain_reg <= ONE_Q30[30:0], "gain above 1.0")
    `SKOF_ASSERT_IMP(a_restart_outlier, m_valid_reg && m_rst_reg, m_outl_reg, "restart without outlier")
    `SKOF_ASSERT_NXT(a_accept_starts, s_valid && s_ready, state_reg == S_CHECK, "accept did not start work")
    `SKOF_ASSERT_IMP(a_div_cnt_range, state_reg == S_DIV, div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1), "divider step out of range")

endmodule
